>>> src/lsqovc_pkg.sv
package lsqovc_pkg;

  localparam int ENTRIES    = 32;
  localparam int WORD_SHIFT = 3;
  localparam int ADDR_W     = 32;
  localparam int WORD_W     = ADDR_W - WORD_SHIFT;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RED_N      = 1 << IDX_W;
  localparam int LVL_W      = $clog2(IDX_W + 1);

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXECUTE = 2'd1;
  localparam logic [1:0] OP_REMOVE  = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] inst_id;
    logic [31:0] address;
    logic [31:0] pc;
    logic        is_store;
  } in_word_t;

  typedef struct packed {
    logic        violation;
    logic [15:0] violating_id;
    logic        forwarded;
    logic        queue_full;
  } out_word_t;

  typedef struct packed {
    logic item_load;
    logic find;
    logic cmp;
    logic red_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic exec_hit;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FIND = 5'b00010,
    S_CMP  = 5'b00100,
    S_RED  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

>>> src/lsq_order_violation_check_core.sv
// Flow: insert, remove, unused opcodes and an execute that misses go IDLE, FIND, DONE;
//   an execute that hits goes IDLE, FIND, CMP, one RED step per tree level, then DONE.
// A new word is taken only in IDLE, so each word finishes before the next is accepted;
//   DONE waits for a free output slot; the halving tree picks the youngest conflicting load.
// Reset: synchronous, active-low rst_n; empties the queue and the output register.
module lsq_order_violation_check_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lsqovc_pkg::in_word_t in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lsqovc_pkg::out_word_t out_word
);
  import lsqovc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  out_word_t  result;
  logic       out_free;

  logic      out_valid_r;
  out_word_t out_word_r;

  // the output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  lsqovc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  lsqovc_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .cmd     (cmd),
    .status  (status),
    .result  (result)
  );

  // output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> src/lsqovc_ctrl.sv
module lsqovc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   out_free,
  input  lsqovc_pkg::dp_status_t status,
  output lsqovc_pkg::ctrl_cmd_t  cmd
);
  import lsqovc_pkg::*;

  state_t           state_r, state_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_FIND;
        end
      end
      S_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = status.exec_hit ? S_CMP : S_DONE;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        lvl_nxt   = '0;
        state_nxt = S_RED;
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        lvl_nxt      = lvl_r + LVL_W'(1);
        if (lvl_r == LVL_W'(IDX_W - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lvl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_find: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_FIND))
    else $error("accepted word did not move to lookup");

  a_red_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RED) |-> (lvl_r < LVL_W'(IDX_W)))
    else $error("reduction level out of range");

  a_cmp_after_find: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ($past(state_r) == S_FIND && $past(status.exec_hit)))
    else $error("compare entered without a lookup hit");
`endif

endmodule

>>> src/lsqovc_dp.sv
module lsqovc_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lsqovc_pkg::in_word_t   in_word,
  input  lsqovc_pkg::ctrl_cmd_t  cmd,
  output lsqovc_pkg::dp_status_t status,
  output lsqovc_pkg::out_word_t  result
);
  import lsqovc_pkg::*;

  // item registers
  logic [1:0]        item_op_r;
  logic [15:0]       item_id_r;
  logic [WORD_W-1:0] item_word_r;
  logic [31:0]       item_pc_r;
  logic              item_st_r;

  // entry storage
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] exec_r;
  logic [ENTRIES-1:0] fwdf_r;
  logic [15:0]        id_r   [ENTRIES];
  logic [WORD_W-1:0]  word_r [ENTRIES];
  logic [31:0]        pc_r   [ENTRIES];
  logic [ENTRIES-1:0] st_r;

  idx_t        sel_r;
  logic        exec_hit_r;
  logic        full_r;
  logic        fwd_r;
  logic        red_v_r  [RED_N];
  logic [15:0] red_id_r [RED_N];

  logic [ENTRIES-1:0] match_vec, free_vec, cand, fwd_hit;
  logic               match_any, free_any, fwd_new;
  idx_t               match_idx, free_idx;
  logic [15:0]        e_id;
  logic [WORD_W-1:0]  e_word;
  logic [31:0]        e_pc;
  logic               e_st, e_fwd;
  logic               cand_pad   [RED_N];
  logic [15:0]        cand_id    [RED_N];

  function automatic idx_t lowest(input logic [ENTRIES-1:0] v);
    idx_t k;
    k = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) k = idx_t'(i);
    end
    return k;
  endfunction

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_r[i] && (id_r[i] == item_id_r);
      free_vec[i]  = !valid_r[i];
    end
  end

  assign match_any = |match_vec;
  assign free_any  = |free_vec;
  assign match_idx = lowest(match_vec);
  assign free_idx  = lowest(free_vec);

  assign status.exec_hit = (item_op_r == OP_EXECUTE) && match_any;

  assign e_id   = id_r[sel_r];
  assign e_word = word_r[sel_r];
  assign e_pc   = pc_r[sel_r];
  assign e_st   = st_r[sel_r];
  assign e_fwd  = fwdf_r[sel_r];

  // per-entry conflict compare against the executing entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      logic same;
      same = (idx_t'(i) != sel_r) && valid_r[i] && (word_r[i] == e_word);
      cand[i]    = same && (id_r[i] > e_id) && exec_r[i] && (pc_r[i] != e_pc) &&
                   e_st && !st_r[i];
      fwd_hit[i] = same && !(id_r[i] > e_id) && st_r[i] && exec_r[i];
    end
  end

  assign fwd_new = !e_st && !e_fwd && (|fwd_hit);

  // pad the candidate set to a power of two for the halving tree
  for (genvar g = 0; g < RED_N; g++) begin : g_pad
    if (g < ENTRIES) begin : g_real
      assign cand_pad[g] = cand[g];
      assign cand_id[g]  = id_r[g];
    end else begin : g_fill
      assign cand_pad[g] = 1'b0;
      assign cand_id[g]  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_op_r   <= in_word.opcode;
      item_id_r   <= in_word.inst_id;
      item_word_r <= in_word.address[ADDR_W-1:WORD_SHIFT];
      item_pc_r   <= in_word.pc;
      item_st_r   <= in_word.is_store;
    end
    if (cmd.find) begin
      if (item_op_r == OP_INSERT && free_any) begin
        id_r[free_idx]   <= item_id_r;
        word_r[free_idx] <= item_word_r;
        pc_r[free_idx]   <= item_pc_r;
        st_r[free_idx]   <= item_st_r;
      end
      sel_r      <= match_idx;
      exec_hit_r <= status.exec_hit;
      full_r     <= (item_op_r == OP_INSERT) && !free_any;
      fwd_r      <= 1'b0;
    end
    if (cmd.cmp) begin
      fwd_r <= fwd_new;
      for (int i = 0; i < RED_N; i++) begin
        red_v_r[i]  <= cand_pad[i];
        red_id_r[i] <= cand_id[i];
      end
    end
    if (cmd.red_step) begin
      for (int i = 0; i < RED_N / 2; i++) begin
        if (red_v_r[2*i+1] && (!red_v_r[2*i] || red_id_r[2*i+1] > red_id_r[2*i])) begin
          red_v_r[i]  <= 1'b1;
          red_id_r[i] <= red_id_r[2*i+1];
        end else begin
          red_v_r[i]  <= red_v_r[2*i];
          red_id_r[i] <= red_id_r[2*i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      exec_r  <= '0;
      fwdf_r  <= '0;
    end else begin
      if (cmd.find) begin
        if (item_op_r == OP_INSERT && free_any) begin
          valid_r[free_idx] <= 1'b1;
          exec_r[free_idx]  <= 1'b0;
          fwdf_r[free_idx]  <= 1'b0;
        end
        if (item_op_r == OP_REMOVE && match_any) begin
          valid_r[match_idx] <= 1'b0;
        end
      end
      if (cmd.cmp) begin
        exec_r[sel_r] <= 1'b1;
        if (fwd_new) begin
          fwdf_r[sel_r] <= 1'b1;
        end
      end
    end
  end

  assign result.violation    = exec_hit_r && red_v_r[0];
  assign result.violating_id = (exec_hit_r && red_v_r[0]) ? red_id_r[0] : 16'd0;
  assign result.forwarded    = exec_hit_r && fwd_r;
  assign result.queue_full   = full_r;

`ifndef SYNTHESIS
  a_cmp_sel_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cmp |-> (valid_r[sel_r] && id_r[sel_r] == item_id_r))
    else $error("compare on an entry that does not hold the executing id");
`endif

endmodule

>>> test/tb_lsq_order_violation_check_core.sv
`timescale 1ns / 1ps

module tb_lsq_order_violation_check_core;
  import lsqovc_pkg::*;

  // Opcode 3 is not decoded by the block; it must come back as an all-zero word.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_ITEMS  = 425;

  localparam out_word_t NO_HIT    = '0;
  localparam out_word_t VIOL_FFFF = '{1'b1, 16'hffff, 1'b0, 1'b0};

  // One row of the directed table: the word to send, and a hand-written
  // expectation where one is obvious. Rows with typed = 0 use the predictor.
  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t want;
  } dir_row_t;

  localparam int DIR_N = 27;

  // Word 0x20 is shared by addresses 0x100..0x107; word 0x1fffffff by the top
  // eight bytes. Ids and pcs are picked so each special case fires once.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // empty queue: execute, remove and an unused opcode do nothing
    '{'{OP_EXECUTE, 16'h0005, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, NO_HIT},
    '{'{OP_REMOVE,  16'h0005, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, NO_HIT},
    '{'{OP_UNUSED,  16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1}, 1'b1, NO_HIT},
    // two loads and an older store on the same word
    '{'{OP_INSERT,  16'h0010, 32'h0000_0100, 32'h0000_000a, 1'b0}, 1'b1, NO_HIT},
    '{'{OP_INSERT,  16'h0020, 32'h0000_0104, 32'h0000_000b, 1'b0}, 1'b1, NO_HIT},
    '{'{OP_INSERT,  16'h0008, 32'h0000_0107, 32'h0000_000c, 1'b1}, 1'b1, NO_HIT},
    '{'{OP_EXECUTE, 16'h0010, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_HIT},
    '{'{OP_EXECUTE, 16'h0020, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_HIT},
    // late store: youngest younger executed load is flagged
    '{'{OP_EXECUTE, 16'h0008, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_HIT},
    // load with the store's pc: forwarded once, never a violator
    '{'{OP_INSERT,  16'h0030, 32'h0000_0100, 32'h0000_000c, 1'b0}, 1'b1, NO_HIT},
    '{'{OP_EXECUTE, 16'h0030, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_HIT},
    '{'{OP_EXECUTE, 16'h0030, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_HIT},
    '{'{OP_EXECUTE, 16'h0008, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_HIT},
    // duplicate id: lookup and remove take the lowest slot
    '{'{OP_INSERT,  16'h0010, 32'h0000_0100, 32'h0000_000d, 1'b1}, 1'b1, NO_HIT},
    '{'{OP_EXECUTE, 16'h0010, 32'hffff_ffff, 32'hffff_ffff, 1'b1}, 1'b0, NO_HIT},
    '{'{OP_REMOVE,  16'h0010, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, NO_HIT},
    '{'{OP_EXECUTE, 16'h0010, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_HIT},
    // extreme ids and addresses on the top word
    '{'{OP_INSERT,  16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0}, 1'b1, NO_HIT},
    '{'{OP_INSERT,  16'h0000, 32'hffff_fff8, 32'h0000_0000, 1'b1}, 1'b1, NO_HIT},
    '{'{OP_EXECUTE, 16'hffff, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_HIT},
    '{'{OP_EXECUTE, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, VIOL_FFFF},
    // drain the queue
    '{'{OP_REMOVE,  16'hffff, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, NO_HIT},
    '{'{OP_REMOVE,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, NO_HIT},
    '{'{OP_REMOVE,  16'h0010, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, NO_HIT},
    '{'{OP_REMOVE,  16'h0020, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, NO_HIT},
    '{'{OP_REMOVE,  16'h0030, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, NO_HIT},
    '{'{OP_REMOVE,  16'h0008, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, NO_HIT}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // Idle and stall rates in percent, changed only between phases.
  int send_pct = 0;
  int recv_pct = 0;

  // Long receiver hold-off: the stimulus bumps hold_req, the stall process
  // notices the change and counts the hold down on its own.
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int        mismatches = 0;
  int        cycle_cnt  = 0;
  out_word_t verdict_q [$];
  out_word_t want;

  // Shadow copy of the queue, updated once per accepted word.
  bit              q_valid [ENTRIES];
  logic [15:0]     q_id    [ENTRIES];
  logic [WORD_W-1:0] q_word [ENTRIES];
  logic [31:0]     q_pc    [ENTRIES];
  bit              q_store [ENTRIES];
  bit              q_exec  [ENTRIES];
  bit              q_fwd   [ENTRIES];

  logic [15:0]       next_id;
  logic [WORD_W-1:0] word_pool [4];
  logic [31:0]       pc_pool   [4];

  lsq_order_violation_check_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Lowest valid slot holding this id, or -1.
  function automatic int slot_of(input logic [15:0] id);
    for (int i = 0; i < ENTRIES; i++) begin
      if (q_valid[i] && q_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Apply one word to the shadow queue and return the verdict the block owes.
  function automatic out_word_t disambiguate(input in_word_t w);
    out_word_t   r;
    int          s;
    bit          found;
    logic [15:0] best;
    r     = '0;
    s     = -1;
    found = 1'b0;
    best  = '0;
    case (w.opcode)
      OP_INSERT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!q_valid[i]) begin
            s = i;
            break;
          end
        end
        if (s < 0) begin
          r.queue_full = 1'b1;
        end else begin
          q_valid[s] = 1'b1;
          q_id[s]    = w.inst_id;
          q_word[s]  = w.address[ADDR_W-1:WORD_SHIFT];
          q_pc[s]    = w.pc;
          q_store[s] = w.is_store;
          q_exec[s]  = 1'b0;
          q_fwd[s]   = 1'b0;
        end
      end
      OP_EXECUTE: begin
        s = slot_of(w.inst_id);
        if (s >= 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (i == s || !q_valid[i] || q_word[i] != q_word[s]) continue;
            if (q_id[i] > q_id[s]) begin
              // younger entry: only an executed load with another pc counts
              if (q_exec[i] && q_pc[i] != q_pc[s] && q_store[s] && !q_store[i] &&
                  (!found || q_id[i] > best)) begin
                best  = q_id[i];
                found = 1'b1;
              end
            end else if (!q_fwd[s] && !q_store[s] && q_store[i] && q_exec[i]) begin
              // older or equal id: an executed store forwards to this load
              q_fwd[s]    = 1'b1;
              r.forwarded = 1'b1;
            end
          end
          if (found) begin
            r.violation    = 1'b1;
            r.violating_id = best;
          end
          q_exec[s] = 1'b1;
        end
      end
      OP_REMOVE: begin
        s = slot_of(w.inst_id);
        if (s >= 0) q_valid[s] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Id of a random live entry; call only with at least one entry live.
  function automatic logic [15:0] live_id();
    int s;
    s = $urandom_range(ENTRIES - 1);
    while (!q_valid[s]) s = $urandom_range(ENTRIES - 1);
    return q_id[s];
  endfunction

  // Offer one word, hold it until the block takes it, then log the verdict.
  task automatic offer(input in_word_t w, input logic typed, input out_word_t typed_want);
    out_word_t pred;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    pred = disambiguate(w);
    verdict_q.push_back(typed ? typed_want : pred);
  endtask

  // Mostly well-formed traffic on a few shared words and pcs, so that
  // conflicts, forwards and violations are common; a little noise on top.
  task automatic run_random(input int n_items);
    in_word_t w;
    int       live;
    int       pick;
    int       ins_cut;
    int       fill_left;
    fill_left = 0;
    next_id   = 16'($urandom);
    for (int j = 0; j < 4; j++) begin
      word_pool[j] = WORD_W'($urandom);
      pc_pool[j]   = $urandom;
    end
    for (int k = 0; k < n_items; k++) begin
      live = 0;
      for (int i = 0; i < ENTRIES; i++) live += q_valid[i];
      // now and then, insert until the queue overflows twice
      if (k % 150 == 75) fill_left = ENTRIES - live + 2;
      pick    = $urandom_range(99);
      ins_cut = (live > 24) ? 25 : 45;
      // ignored fields still toggle every bit
      w.opcode   = OP_EXECUTE;
      w.inst_id  = 16'($urandom);
      w.address  = $urandom;
      w.pc       = $urandom;
      w.is_store = 1'($urandom);
      if (fill_left == 0 && pick < 5) begin
        w.opcode = 2'($urandom);
      end else if (fill_left > 0 || live == 0 || pick < ins_cut) begin
        if (fill_left > 0) fill_left--;
        w.opcode = OP_INSERT;
        if (live > 0 && $urandom_range(9) == 0) begin
          w.inst_id = live_id();
        end else begin
          w.inst_id = next_id;
          next_id   = next_id + 16'($urandom_range(1, 3));
        end
        if ($urandom_range(4) != 0)
          w.address = {word_pool[$urandom_range(3)], WORD_SHIFT'($urandom)};
        if ($urandom_range(4) != 0) w.pc = pc_pool[$urandom_range(3)];
      end else begin
        w.opcode  = (pick < ins_cut + 35) ? OP_EXECUTE : OP_REMOVE;
        w.inst_id = live_id();
      end
      offer(w, 1'b0, NO_HIT);
    end
  endtask

  // Receiver: a long hold-off when asked, random stalls otherwise.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Compare each result word with the oldest verdict, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result word %h with nothing expected", $time, out_word);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (out_word.violation !== want.violation) begin
          $display("%0t: violation expected %0b got %0b",
                   $time, want.violation, out_word.violation);
          mismatches++;
        end
        if (out_word.violating_id !== want.violating_id) begin
          $display("%0t: violating_id expected %h got %h",
                   $time, want.violating_id, out_word.violating_id);
          mismatches++;
        end
        if (out_word.forwarded !== want.forwarded) begin
          $display("%0t: forwarded expected %0b got %0b",
                   $time, want.forwarded, out_word.forwarded);
          mismatches++;
        end
        if (out_word.queue_full !== want.queue_full) begin
          $display("%0t: queue_full expected %0b got %0b",
                   $time, want.queue_full, out_word.queue_full);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) q_valid[i] = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, back to back
    for (int r = 0; r < DIR_N; r++) offer(DIR_ROWS[r].w, DIR_ROWS[r].typed, DIR_ROWS[r].want);

    // no idling; hold the receiver off while the sender keeps pushing
    hold_req <= hold_req + 1;
    run_random(PHASE_ITEMS);

    send_pct = 55;
    recv_pct = 0;
    run_random(PHASE_ITEMS);

    send_pct = 0;
    recv_pct = 55;
    run_random(PHASE_ITEMS);

    send_pct = 31;
    recv_pct = 31;
    run_random(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    // catch any stray word after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
